/* design/swmo_pkg.sv */
`default_nettype none
package swmo_pkg;

  // Capacity of the stack and the widths that follow from it, plus the word and count widths.
  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  // Operation codes.
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_MID  = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Control broadcast from the stack controller to every cell.
  typedef struct packed {
    logic             push;
    logic             del;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] mid_idx;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] rd_idx;
  } ctrl_t;

endpackage
`default_nettype wire

/* design/stack_with_middle_ops_unit.sv */
`default_nettype none
// Bounded LIFO stack of signed 32-bit words with access to the middle entry
// (index floor((count-1)/2) from the bottom). Operations are push, pop,
// get middle and delete middle: a word is accepted on every clock edge where
// in_valid and in_ready are high, and its result word appears on the
// out_ port from the next cycle, held until out_ready. The entries
// live in a row of cells; a delete moves every cell between the middle and
// the top down by one in that same cycle, so the rate is one word per clock
// whenever the result side keeps up. Status reports empty for pop, get middle
// or delete middle on an empty stack and full for a push at capacity; the
// stack is then left unchanged. Count is the number of entries afterward.
module stack_with_middle_ops_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic        [1:0]                    in_op,
  input  wire logic signed [swmo_pkg::WORD_W-1:0]   in_push_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [swmo_pkg::WORD_W-1:0]   out_value,
  output logic             [1:0]                    out_status,
  output logic             [swmo_pkg::COUNT_W-1:0]  out_count
);

  logic [swmo_pkg::CNT_W-1:0]   count_r;
  logic [swmo_pkg::CNT_W-1:0]   count_nxt;
  logic                         out_valid_r;
  logic [swmo_pkg::WORD_W-1:0]  out_value_r;
  logic [swmo_pkg::WORD_W-1:0]  out_value_nxt;
  logic [1:0]                   out_status_r;
  logic [1:0]                   out_status_nxt;
  logic [swmo_pkg::COUNT_W-1:0] out_count_r;

  logic                         fire;
  logic                         empty;
  logic                         full;
  logic [swmo_pkg::CNT_W-1:0]   count_m1;
  swmo_pkg::ctrl_t              ctrl;
  logic [swmo_pkg::WORD_W-1:0]  cell_word [swmo_pkg::DEPTH];
  logic [swmo_pkg::WORD_W-1:0]  cell_rd   [swmo_pkg::DEPTH];
  logic [swmo_pkg::WORD_W-1:0]  rd_word;

  // Handshake: a new word is taken whenever the result register is free or
  // is being emptied in this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  assign empty    = (count_r == '0);
  assign full     = (count_r == swmo_pkg::CNT_W'(swmo_pkg::DEPTH));
  assign count_m1 = count_r - 1'b1;

  // Control broadcast to the cells.
  always_comb begin
    ctrl.push     = fire && (in_op == swmo_pkg::OP_PUSH) && !full;
    ctrl.del      = fire && (in_op == swmo_pkg::OP_DEL) && !empty;
    ctrl.wr_idx   = swmo_pkg::IDX_W'(count_r);
    ctrl.last_idx = swmo_pkg::IDX_W'(count_m1);
    ctrl.mid_idx  = swmo_pkg::IDX_W'(count_m1 >> 1);
    ctrl.rd_idx   = (in_op == swmo_pkg::OP_POP) ? ctrl.last_idx : ctrl.mid_idx;
  end

  // Row of cells; each one hands its word to the cell below.
  for (genvar gi = 0; gi < swmo_pkg::DEPTH; gi++) begin : g_cell
    logic [swmo_pkg::WORD_W-1:0] above;
    if (gi == swmo_pkg::DEPTH - 1) begin : g_top
      assign above = '0;
    end else begin : g_mid
      assign above = cell_word[gi+1];
    end
    swmo_cell u_cell (
      .clk        (clk),
      .idx        (swmo_pkg::IDX_W'(gi)),
      .ctrl       (ctrl),
      .push_word  (in_push_value),
      .above_word (above),
      .word       (cell_word[gi]),
      .rd_word    (cell_rd[gi])
    );
  end

  // Only the selected cell drives a nonzero read word.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < swmo_pkg::DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Result and next count for the operation.
  always_comb begin
    count_nxt      = count_r;
    out_value_nxt  = '0;
    out_status_nxt = swmo_pkg::ST_OK;
    case (in_op)
      swmo_pkg::OP_PUSH: begin
        if (full) begin
          out_status_nxt = swmo_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      swmo_pkg::OP_POP: begin
        if (empty) begin
          out_status_nxt = swmo_pkg::ST_EMPTY;
        end else begin
          count_nxt     = count_m1;
          out_value_nxt = rd_word;
        end
      end
      swmo_pkg::OP_MID: begin
        if (empty) begin
          out_status_nxt = swmo_pkg::ST_EMPTY;
        end else begin
          out_value_nxt = rd_word;
        end
      end
      default: begin
        if (empty) begin
          out_status_nxt = swmo_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_m1;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= swmo_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  // The fill count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= swmo_pkg::CNT_W'(swmo_pkg::DEPTH))
    else $error("fill count above capacity");

  // A push with room grows the stack by one.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_op == swmo_pkg::OP_PUSH) && !full
    |=> count_r == swmo_pkg::CNT_W'($past(count_r) + 1'b1))
    else $error("push did not grow the stack");

  // A push at capacity reports full and leaves the count alone.
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_op == swmo_pkg::OP_PUSH) && full
    |=> (out_status_r == swmo_pkg::ST_FULL) && (count_r == $past(count_r)))
    else $error("push at capacity not rejected");

  // Any removal or read on an empty stack reports empty with a zero word.
  a_empty_op: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_op != swmo_pkg::OP_PUSH) && empty
    |=> (out_status_r == swmo_pkg::ST_EMPTY) && (out_value_r == '0) && (count_r == '0))
    else $error("operation on empty stack not rejected");

endmodule
`default_nettype wire

/* design/swmo_cell.sv */
`default_nettype none
module swmo_cell (
  input  wire logic                          clk,
  input  wire logic [swmo_pkg::IDX_W-1:0]    idx,
  input  wire swmo_pkg::ctrl_t               ctrl,
  input  wire logic [swmo_pkg::WORD_W-1:0]   push_word,
  input  wire logic [swmo_pkg::WORD_W-1:0]   above_word,
  output logic      [swmo_pkg::WORD_W-1:0]   word,
  output logic      [swmo_pkg::WORD_W-1:0]   rd_word
);

  logic [swmo_pkg::WORD_W-1:0] data_r;
  logic [swmo_pkg::WORD_W-1:0] data_nxt;
  logic                        load_push;
  logic                        shift_down;

  // This cell takes the pushed word when it is the first free slot, and takes
  // its upper neighbor's word when it sits between the middle and the top
  // during a delete.
  assign load_push  = ctrl.push && (idx == ctrl.wr_idx);
  assign shift_down = ctrl.del && (idx >= ctrl.mid_idx) && (idx < ctrl.last_idx);

  always_comb begin
    data_nxt = data_r;
    if (load_push) begin
      data_nxt = push_word;
    end else if (shift_down) begin
      data_nxt = above_word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // The word goes down to the neighbor below; the read word is zero unless
  // this cell is the one selected, so the controller can OR all cells.
  assign word    = data_r;
  assign rd_word = (idx == ctrl.rd_idx) ? data_r : '0;

endmodule
`default_nettype wire
